>>> rtl/core/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// shared types and constants of the coprime range counter
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int MAX_PRIMES_DEF = 9;
  localparam int RANGE_BITS_DEF = 63;
  localparam int FIELD_BITS     = 63;
  localparam int BASE_BITS      = 31;
  localparam int IN_BYTES_BITS  = 160;
  localparam int OUT_BYTES_BITS = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV1,
    ST_DIV2,
    ST_TAIL,
    ST_SUBSET,
    ST_PROD,
    ST_QUOT,
    ST_FIN
  } cpc_state_t;

endpackage

>>> rtl/core/coprime_count_in_range.sv
// ----------------------------------------------------------------------------
// coprime_count_in_range
// counts the integers of [low, high] that are coprime to a base k
// ----------------------------------------------------------------------------
// input channel s_*: one transfer carries range_low, range_high, coprime_base
// output channel m_*: one transfer per query carries coprime_count
// one restoring divider (one quotient bit per cycle) does all the work under
// a small sequencer; a trial division of k yields BASE_BITS quotient bits, a
// division of a range bound FIELD_BITS quotient bits:
//   factoring: trial division of k by d = 2, 3, ... while d*d <= rest,
//   each step one division plus one more per repeated factor, up to about
//   46k steps for a prime k near 2^31
//   counting: for each nonempty subset of the kept primes (up to
//   2^MAX_PRIMES - 1) a product of up to MAX_PRIMES multiplies and one
//   division, done once for high and, if low is nonzero, once for low - 1
// s_tready is high only while the sequencer is idle; one query at a time
// the result waits in an output register; the next query is taken while it
// waits, and a stalled receiver only holds the sequencer at its last step
// reset (rst, synchronous) returns to idle and drops m_tvalid
// ----------------------------------------------------------------------------
module coprime_count_in_range
  import cpc_pkg::*;
#(
  parameter int MAX_PRIMES = MAX_PRIMES_DEF,
  parameter int RANGE_BITS = RANGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_BYTES_BITS-1:0]  s_tdata,  // range_low, range_high, coprime_base
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_BYTES_BITS-1:0] m_tdata   // coprime_count
);

  localparam int PCW = $clog2(MAX_PRIMES + 1);
  localparam int PIW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int SW  = MAX_PRIMES + 1;
  localparam int DCW = $clog2(FIELD_BITS + 1);

  cpc_state_t state, state_next;

  logic [RANGE_BITS-1:0] lo, hi, xval;
  logic [BASE_BITS-1:0]  rest, prod;
  logic [15:0]           d;
  logic [31:0]           sq;
  logic [PCW-1:0]        pcount, pidx;
  logic [BASE_BITS-1:0]  plist [MAX_PRIMES];
  logic [SW-1:0]         subset, subset_end;
  logic                  parity, pass_lo;
  logic [FIELD_BITS-1:0] acc;

  logic [FIELD_BITS-1:0] dv_q;
  logic [BASE_BITS:0]    dv_r, dv_trial;
  logic [BASE_BITS-1:0]  dv_d;
  logic [DCW-1:0]        dv_cnt;
  logic                  dv_done, dv_ge;
  logic [2*BASE_BITS-1:0] mul;
  logic                  out_free;

  assign sq         = 32'(d) * 32'(d);
  assign subset_end = SW'(1) << pcount;
  assign dv_trial   = {dv_r[BASE_BITS-1:0], dv_q[FIELD_BITS-1]};
  assign dv_ge      = dv_trial >= {1'b0, dv_d};
  assign dv_done    = dv_cnt == '0;
  assign mul        = prod * plist[pidx[PIW-1:0]];
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_CHECK;
      ST_CHECK:  state_next = (sq > {1'b0, rest}) ? ST_TAIL : ST_DIV1;
      ST_DIV1:   if (dv_done) state_next = (dv_r == '0) ? ST_DIV2 : ST_CHECK;
      ST_DIV2: begin
        if (dv_done && dv_r != '0) state_next = (rest == BASE_BITS'(1)) ? ST_TAIL : ST_CHECK;
      end
      ST_TAIL:   state_next = (lo > hi) ? ST_FIN : ST_SUBSET;
      ST_SUBSET: begin
        if (subset == subset_end) begin
          if (pass_lo || lo == '0) state_next = ST_FIN;
        end else begin
          state_next = ST_PROD;
        end
      end
      ST_PROD:   if (pidx == pcount) state_next = ST_QUOT;
      ST_QUOT:   if (dv_done) state_next = ST_SUBSET;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) m_tdata <= {1'b0, acc};
  end

  // sequencer datapath and shared divider
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0;
      dv_cnt <= '0;
    end else begin
      if (!dv_done) begin
        dv_cnt <= dv_cnt - DCW'(1);
        dv_q   <= {dv_q[FIELD_BITS-2:0], dv_ge};
        dv_r   <= dv_ge ? (dv_trial - {1'b0, dv_d}) : dv_trial;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            lo     <= s_tdata[RANGE_BITS-1:0];
            hi     <= s_tdata[FIELD_BITS +: RANGE_BITS];
            rest   <= s_tdata[2*FIELD_BITS +: BASE_BITS];
            d      <= 16'd2;
            pcount <= '0;
          end
        end
        ST_CHECK: begin
          if (sq <= {1'b0, rest}) begin
            dv_q   <= FIELD_BITS'(rest) << (FIELD_BITS - BASE_BITS);
            dv_r   <= '0;
            dv_d   <= BASE_BITS'(d);
            dv_cnt <= DCW'(BASE_BITS);
          end
        end
        ST_DIV1, ST_DIV2: begin
          if (dv_done) begin
            if (dv_r == '0) begin
              if (state == ST_DIV1 && pcount < PCW'(MAX_PRIMES)) begin
                plist[pcount[PIW-1:0]] <= BASE_BITS'(d);
                pcount <= pcount + PCW'(1);
              end
              rest   <= dv_q[BASE_BITS-1:0];
              dv_q   <= FIELD_BITS'(dv_q[BASE_BITS-1:0]) << (FIELD_BITS - BASE_BITS);
              dv_r   <= '0;
              dv_cnt <= DCW'(BASE_BITS);
            end else begin
              d <= d + 16'd1;
            end
          end
        end
        ST_TAIL: begin
          if (rest > BASE_BITS'(1) && pcount < PCW'(MAX_PRIMES)) begin
            plist[pcount[PIW-1:0]] <= rest;
            pcount <= pcount + PCW'(1);
          end
          acc     <= (lo > hi) ? '0 : FIELD_BITS'(hi);
          xval    <= hi;
          pass_lo <= 1'b0;
          subset  <= SW'(1);
        end
        ST_SUBSET: begin
          if (subset == subset_end) begin
            if (!pass_lo && lo != '0) begin
              pass_lo <= 1'b1;
              xval    <= lo - RANGE_BITS'(1);
              acc     <= acc - FIELD_BITS'(lo - RANGE_BITS'(1));
              subset  <= SW'(1);
            end
          end else begin
            prod   <= BASE_BITS'(1);
            pidx   <= '0;
            parity <= 1'b0;
          end
        end
        ST_PROD: begin
          if (pidx == pcount) begin
            dv_q   <= FIELD_BITS'(xval);
            dv_r   <= '0;
            dv_d   <= prod;
            dv_cnt <= DCW'(FIELD_BITS);
          end else begin
            if (subset[pidx]) begin
              prod   <= mul[BASE_BITS-1:0];
              parity <= !parity;
            end
            pidx <= pidx + PCW'(1);
          end
        end
        ST_QUOT: begin
          if (dv_done) begin
            if (parity ^ pass_lo) acc <= acc - FIELD_BITS'(dv_q);
            else                  acc <= acc + FIELD_BITS'(dv_q);
            subset <= subset + SW'(1);
          end
        end
        ST_FIN: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/cpc_check.sv
// ----------------------------------------------------------------------------
// cpc_check
// port-level checks of the coprime range counter
// ----------------------------------------------------------------------------
module cpc_check
  import cpc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_BYTES_BITS-1:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready during a query");

  a_not_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result one cycle after transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind coprime_count_in_range cpc_check u_cpc_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/coprime_count_checker.sv
// ----------------------------------------------------------------------------
// coprime_count_checker
// watches both stream channels of the coprime range counter, predicts the
// count of every accepted query and compares it with the returned transfer
// ----------------------------------------------------------------------------
module coprime_count_checker
  import cpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [IN_BYTES_BITS-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [OUT_BYTES_BITS-1:0] m_tdata,
  output int                        errors,
  output int                        pending
);

  localparam int MAX_KEPT   = MAX_PRIMES_DEF;
  localparam int FIFO_DEPTH = 4;

  logic [OUT_BYTES_BITS-1:0] count_fifo [FIFO_DEPTH];
  logic [1:0]                wr_ptr;
  logic [1:0]                rd_ptr;
  int                        fill;
  longint unsigned           kept_primes[MAX_KEPT];
  int                        kept_count;

  function automatic void factor_base(longint unsigned k);
    longint unsigned rest;
    longint unsigned d;
    rest = k;
    kept_count = 0;
    for (d = 2; d * d <= rest; d++) begin
      if (rest % d == 0) begin
        if (kept_count < MAX_KEPT) begin
          kept_primes[kept_count] = d;
          kept_count++;
        end
        while (rest % d == 0) rest = rest / d;
      end
      if (rest == 1) break;
    end
    if (rest > 1 && kept_count < MAX_KEPT) begin
      kept_primes[kept_count] = rest;
      kept_count++;
    end
  endfunction

  function automatic longint unsigned coprime_upto(longint unsigned x);
    longint unsigned hit;
    longint unsigned prod;
    int              bits;
    hit = 0;
    for (int subset = 1; subset < (1 << kept_count); subset++) begin
      prod = 1;
      bits = 0;
      for (int i = 0; i < kept_count; i++) begin
        if ((subset >> i) & 1) begin
          bits++;
          prod = prod * kept_primes[i];
        end
      end
      if (prod == 0) continue;
      if (bits & 1) hit = hit + x / prod;
      else hit = hit - x / prod;
    end
    return x - hit;
  endfunction

  function automatic logic [OUT_BYTES_BITS-1:0] predict_count(
    logic [IN_BYTES_BITS-1:0] query
  );
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned k;
    longint unsigned upper;
    longint unsigned lower;
    lo = 64'(query[FIELD_BITS-1:0]);
    hi = 64'(query[2*FIELD_BITS-1:FIELD_BITS]);
    k  = 64'(query[2*FIELD_BITS+BASE_BITS-1:2*FIELD_BITS]);
    factor_base(k);
    if (lo > hi) return '0;
    upper = coprime_upto(hi);
    lower = (lo == 0) ? 0 : coprime_upto(lo - 1);
    return {1'b0, 63'(upper - lower)};
  endfunction

  logic [OUT_BYTES_BITS-1:0] want;

  always @(posedge clk) begin
    if (rst) begin
      errors  <= 0;
      pending <= 0;
      wr_ptr  = '0;
      rd_ptr  = '0;
      fill    = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        count_fifo[wr_ptr] = predict_count(s_tdata);
        wr_ptr = wr_ptr + 2'd1;
        fill++;
      end
      if (m_tvalid && m_tready) begin
        if (fill == 0) begin
          if (errors < 10) $display("unexpected result transfer: %0d", m_tdata);
          errors <= errors + 1;
        end else begin
          want = count_fifo[rd_ptr];
          rd_ptr = rd_ptr + 2'd1;
          fill--;
          if (m_tdata !== want) begin
            if (errors < 10)
              $display("coprime_count mismatch: expected %0d actual %0d", want, m_tdata);
            errors <= errors + 1;
          end
        end
      end
      pending <= fill;
    end
  end

endmodule

>>> tb/tb_coprime_count_in_range.sv
// ----------------------------------------------------------------------------
// tb_coprime_count_in_range
// directed and random queries against the coprime range counter, with random
// gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
module tb_coprime_count_in_range;
  import cpc_pkg::*;

  localparam longint unsigned RANGE_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam longint          CYCLE_LIMIT = 60_000_000;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_BYTES_BITS-1:0]  s_tdata;   // range_low, range_high, coprime_base
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_BYTES_BITS-1:0] m_tdata;   // coprime_count
  int                        errors;
  int                        pending;
  longint                    cycles;
  bit                        no_gaps;

  int small_primes[15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

  coprime_count_in_range i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  coprime_count_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver side: random stall before each result transfer
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      m_tready <= 1'b0;
      repeat (stall) @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  task automatic send_query(longint unsigned lo, longint unsigned hi, int unsigned k);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {3'b0, k[BASE_BITS-1:0], hi[FIELD_BITS-1:0], lo[FIELD_BITS-1:0]};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic int unsigned smooth_base();
    longint unsigned k;
    longint unsigned p;
    k = 1;
    for (int i = 0; i < 40; i++) begin
      p = small_primes[$urandom_range(0, 14)];
      if (k * p > 64'h7fff_ffff) break;
      k = k * p;
    end
    return int'(k);
  endfunction

  function automatic longint unsigned random_bound();
    case ($urandom_range(0, 2))
      0: return {1'b0, 31'($urandom), 32'($urandom)};
      1: return 64'($urandom_range(0, 1000));
      default: return 64'($urandom) >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     k;
    cycles   = 0;
    no_gaps  = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    send_query(1, 1, 1);
    send_query(1, RANGE_MAX, 0);
    send_query(1, RANGE_MAX, 1);
    send_query(RANGE_MAX, RANGE_MAX, 223092870);
    send_query(1, RANGE_MAX, 223092870);
    send_query(5, 3, 6);
    send_query(RANGE_MAX, 1, 2);
    send_query(0, 100, 6);
    send_query(0, 0, 2);
    send_query(1, 100, 223092870);
    send_query(1, RANGE_MAX, 32'h4000_0000);
    send_query(64'h4000_0000_0000_0000, RANGE_MAX, 30030);
    send_query(100, 100, 97);
    send_query(1, 1000000, 9699690);
    send_query(12345, 67890, 65521);
    send_query(1, RANGE_MAX, 2147483646);

    for (int n = 0; n < 100; n++) begin
      if (n % 20 == 10) no_gaps = 1'b1;
      if (n % 20 == 17) no_gaps = 1'b0;
      k  = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 65535) : smooth_base();
      lo = random_bound();
      hi = random_bound();
      if ($urandom_range(0, 9) < 8 && lo > hi) begin
        lo = lo ^ hi;
        hi = lo ^ hi;
        lo = lo ^ hi;
      end
      send_query(lo, hi, k);
    end
    s_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (pending != 0 || m_tvalid) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> coprime_count_in_range.f
rtl/core/cpc_pkg.sv
rtl/core/coprime_count_in_range.sv
rtl/core/cpc_check.sv
tb/coprime_count_checker.sv
tb/tb_coprime_count_in_range.sv
